FILE: rtl/waypoint_follower_nearest_top_assert.svh
// Assertion macros for the waypoint follower checker.
// Relies on clk and rst being visible where the macros are used.
`ifndef WAYPOINT_FOLLOWER_NEAREST_TOP_ASSERT_SVH
`define WAYPOINT_FOLLOWER_NEAREST_TOP_ASSERT_SVH

// same-cycle implication
`define WFN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WFN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/wfn_pkg.sv
// Shared types and constants of the waypoint follower.
// Used by the controller, the datapath and the top level; no dependencies.
package wfn_pkg;

  // fixed field widths
  localparam int KIND_W     = 2;
  localparam int SLOT_W     = 6;
  localparam int POS_W      = 6;
  localparam int COUNT_W    = 7;
  localparam int DIST_CFG_W = 40;
  localparam int SAT_W      = 64;

  // store depth, tied to the slot and position field widths
  localparam int MAX_WAYPOINTS = 64;

  // configuration port
  localparam int APB_DATA_W = 64;
  localparam int PADDR_W    = 5;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_WAYPOINT_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ARRIVE_DIST_SQ = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOOP_DIST_SQ   = 2'd2;

  localparam logic [COUNT_W-1:0]    COUNT_RESET  = 7'd0;
  localparam logic [DIST_CFG_W-1:0] ARRIVE_RESET = 40'd409600;  // ten units squared
  localparam logic [DIST_CFG_W-1:0] LOOP_RESET   = 40'd36864;   // three units squared

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FOLLOW = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  // which logical position drives the store read
  typedef enum logic [1:0] {
    ADDR_SCAN = 2'd0,
    ADDR_NEXT = 2'd1,
    ADDR_ZERO = 2'd2,
    ADDR_TP   = 2'd3
  } addr_sel_t;

  typedef struct packed {
    logic      capture;
    logic      ram_we;
    logic      clr_known;
    logic      scan_clr;
    logic      rd;
    logic      tag;
    logic      tag_last;
    addr_sel_t addr_sel;
    logic      scan_acc;
    logic      best_take;
    logic      adv;
    logic      keep;
    logic      loop_apply;
    logic      out_load;
    logic      out_hit;
  } wfn_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              empty;
    logic              target_ok;
    logic              scan_last;
    logic              dist_valid;
    logic              dist_last;
    logic              lt_arrive;
    logic              wrap;
    logic              out_free;
  } wfn_sts_t;

endpackage

FILE: rtl/waypoint_follower_nearest_top.sv
// Waypoint follower top level: configuration registers, controller, datapath.
// Depends on wfn_pkg, wfn_ctrl, wfn_dp (and wfn_ram through the datapath).
//
// Input channel (in_valid/in_stall) carries one item: kind, pos_x/y/z, slot.
// Loads write the waypoint store at slot; follow steps and nearest queries
// take the current position. Every item gives exactly one result item on
// the output channel (out_valid/out_stall), held in an output register.
// One item is worked on at a time. A nearest query searches all n
// waypoints in use; a follow step checks a known target, and the path
// start too when the path end is passed, else it picks the nearest waypoint.
// It is ready for the next item in the cycle after its result is loaded.
// The nearest search reads one store entry a cycle through a four-stage
// distance pipe (read, abs diff, squares, saturating sum).
// When the receiver stalls, the result waits in the output register; the
// block finishes the next item and waits before loading its result.
// Reset (rst, synchronous) clears the path state and restores the register
// defaults; the store contents are undefined until loaded. Registers sit on
// an APB-style port at 8-byte spacing, always ready.
module waypoint_follower_nearest_top #(
  parameter int COORD_BITS    = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wfn_pkg::PADDR_W-1:0]         paddr,
  input  logic [wfn_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [wfn_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wfn_pkg::KIND_W-1:0]          kind,
  input  logic signed [COORD_BITS-1:0]        pos_x,
  input  logic signed [COORD_BITS-1:0]        pos_y,
  input  logic signed [COORD_BITS-1:0]        pos_z,
  input  logic [wfn_pkg::SLOT_W-1:0]          slot,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                has_target,
  output logic signed [COORD_BITS-1:0]        target_x,
  output logic signed [COORD_BITS-1:0]        target_y,
  output logic signed [COORD_BITS-1:0]        target_z,
  output logic [wfn_pkg::POS_W-1:0]           target_pos,
  output logic                                walking_back
);
  import wfn_pkg::*;

  logic [COUNT_W-1:0]    waypoint_count;
  logic [DIST_CFG_W-1:0] arrive_dist_sq;
  logic [DIST_CFG_W-1:0] loop_dist_sq;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  reg_wr;

  wfn_cmd_t cmd;
  wfn_sts_t sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      waypoint_count <= COUNT_RESET;
      arrive_dist_sq <= ARRIVE_RESET;
      loop_dist_sq   <= LOOP_RESET;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_WAYPOINT_COUNT: waypoint_count <= pwdata[COUNT_W-1:0];
        REG_ARRIVE_DIST_SQ: arrive_dist_sq <= pwdata[DIST_CFG_W-1:0];
        REG_LOOP_DIST_SQ:   loop_dist_sq   <= pwdata[DIST_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WAYPOINT_COUNT: prdata = APB_DATA_W'(waypoint_count);
      REG_ARRIVE_DIST_SQ: prdata = APB_DATA_W'(arrive_dist_sq);
      REG_LOOP_DIST_SQ:   prdata = APB_DATA_W'(loop_dist_sq);
      default:            prdata = '0;
    endcase
  end

  wfn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  wfn_dp #(
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_count    (waypoint_count),
    .cfg_arrive   (arrive_dist_sq),
    .cfg_loop     (loop_dist_sq),
    .kind         (kind),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .slot         (slot),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .has_target   (has_target),
    .target_x     (target_x),
    .target_y     (target_y),
    .target_z     (target_z),
    .target_pos   (target_pos),
    .walking_back (walking_back)
  );

endmodule

FILE: rtl/wfn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wfn_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/wfn_ctrl.sv
// Sequencing state machine of the waypoint follower.
// Depends on wfn_pkg for the command and status structs.
module wfn_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output wfn_pkg::wfn_cmd_t  cmd,
  input  wfn_pkg::wfn_sts_t  sts
);
  import wfn_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE       = 12'h001,
    S_DECODE     = 12'h002,
    S_SCAN       = 12'h004,
    S_SCAN_WAIT  = 12'h008,
    S_SCAN_DONE  = 12'h010,
    S_CHECK      = 12'h020,
    S_CHECK_WAIT = 12'h040,
    S_LOOP       = 12'h080,
    S_LOOP_WAIT  = 12'h100,
    S_FETCH      = 12'h200,
    S_SEND_HIT   = 12'h400,
    S_SEND_NONE  = 12'h800
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.addr_sel = ADDR_SCAN;
    state_next   = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.kind)
          KIND_LOAD: begin
            cmd.ram_we    = 1'b1;
            cmd.clr_known = 1'b1;
            state_next    = S_SEND_NONE;
          end
          KIND_FOLLOW: begin
            if (sts.empty) begin
              state_next = S_SEND_NONE;
            end else if (sts.target_ok) begin
              state_next = S_CHECK;
            end else begin
              cmd.scan_clr = 1'b1;
              state_next   = S_SCAN;
            end
          end
          KIND_QUERY: begin
            if (sts.empty) begin
              state_next = S_SEND_NONE;
            end else begin
              cmd.scan_clr = 1'b1;
              state_next   = S_SCAN;
            end
          end
          default: begin
            state_next = S_SEND_NONE;
          end
        endcase
      end
      S_SCAN: begin
        cmd.rd       = 1'b1;
        cmd.tag      = 1'b1;
        cmd.tag_last = sts.scan_last;
        cmd.addr_sel = ADDR_SCAN;
        cmd.scan_acc = 1'b1;
        if (sts.scan_last) begin
          state_next = S_SCAN_WAIT;
        end
      end
      S_SCAN_WAIT: begin
        cmd.scan_acc = 1'b1;
        if (sts.dist_valid && sts.dist_last) begin
          state_next = S_SCAN_DONE;
        end
      end
      S_SCAN_DONE: begin
        cmd.best_take = 1'b1;
        state_next    = S_FETCH;
      end
      S_CHECK: begin
        cmd.rd       = 1'b1;
        cmd.tag      = 1'b1;
        cmd.tag_last = 1'b1;
        cmd.addr_sel = ADDR_NEXT;
        state_next   = S_CHECK_WAIT;
      end
      S_CHECK_WAIT: begin
        if (sts.dist_valid) begin
          if (sts.lt_arrive && sts.wrap) begin
            state_next = S_LOOP;
          end else if (sts.lt_arrive) begin
            cmd.adv    = 1'b1;
            state_next = S_FETCH;
          end else begin
            cmd.keep   = 1'b1;
            state_next = S_FETCH;
          end
        end
      end
      S_LOOP: begin
        cmd.rd       = 1'b1;
        cmd.tag      = 1'b1;
        cmd.tag_last = 1'b1;
        cmd.addr_sel = ADDR_ZERO;
        state_next   = S_LOOP_WAIT;
      end
      S_LOOP_WAIT: begin
        if (sts.dist_valid) begin
          cmd.loop_apply = 1'b1;
          state_next     = S_FETCH;
        end
      end
      S_FETCH: begin
        // plain read of the target, kept out of the distance pipe
        cmd.rd       = 1'b1;
        cmd.addr_sel = ADDR_TP;
        state_next   = S_SEND_HIT;
      end
      S_SEND_HIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_hit  = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SEND_NONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/wfn_dp.sv
// Datapath of the waypoint follower: waypoint store, distance pipe,
// nearest tracking, path state and output register. Depends on wfn_pkg, wfn_ram.
module wfn_dp #(
  parameter int COORD_BITS    = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  wfn_pkg::wfn_cmd_t                   cmd,
  output wfn_pkg::wfn_sts_t                   sts,
  input  logic [wfn_pkg::COUNT_W-1:0]         cfg_count,
  input  logic [wfn_pkg::DIST_CFG_W-1:0]      cfg_arrive,
  input  logic [wfn_pkg::DIST_CFG_W-1:0]      cfg_loop,
  input  logic [wfn_pkg::KIND_W-1:0]          kind,
  input  logic signed [COORD_BITS-1:0]        pos_x,
  input  logic signed [COORD_BITS-1:0]        pos_y,
  input  logic signed [COORD_BITS-1:0]        pos_z,
  input  logic [wfn_pkg::SLOT_W-1:0]          slot,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                has_target,
  output logic signed [COORD_BITS-1:0]        target_x,
  output logic signed [COORD_BITS-1:0]        target_y,
  output logic signed [COORD_BITS-1:0]        target_z,
  output logic [wfn_pkg::POS_W-1:0]           target_pos,
  output logic                                walking_back
);
  import wfn_pkg::*;

  localparam int AW    = $clog2(MAX_WAYPOINTS);
  localparam int CNT_W = AW + 1;
  localparam int CB    = COORD_BITS;
  localparam int WP_W  = 3 * CB;
  localparam int SQ_W  = 2 * CB;
  localparam int SUM_W = SQ_W + 2;
  localparam int DW    = (SUM_W > SAT_W) ? SAT_W : SUM_W;
  localparam int CMP_W = (DW > DIST_CFG_W) ? DW : DIST_CFG_W;

  function automatic logic [CB-1:0] abs_diff(logic [CB-1:0] a, logic [CB-1:0] b);
    logic [CB:0] d;
    d = {a[CB-1], a} - {b[CB-1], b};
    return d[CB] ? CB'(-d) : CB'(d);
  endfunction

  // captured item
  logic [KIND_W-1:0] kind_r;
  logic [CB-1:0]     px, py, pz;
  logic [SLOT_W-1:0] slot_r;

  // path state
  logic [AW-1:0] next_pos;
  logic          next_known;
  logic          reversed;
  logic [AW-1:0] tp;
  logic [AW-1:0] scan_p;

  // nearest tracking
  logic [DW-1:0] best_d;
  logic [AW-1:0] best_p;

  // store access
  logic [CNT_W-1:0] n;
  logic [AW-1:0]    lpos;
  logic [CNT_W-1:0] rpos;
  logic [AW-1:0]    raddr;
  logic             slot_ok;
  logic [WP_W-1:0]  rdata;

  // distance pipe
  logic          t0_valid, t0_last;
  logic [AW-1:0] t0_pos;
  logic          s1_valid, s1_last;
  logic [AW-1:0] s1_pos;
  logic [CB-1:0] m_x, m_y, m_z;
  logic          s2_valid, s2_last;
  logic [AW-1:0] s2_pos;
  logic [SQ_W-1:0] sq_x, sq_y, sq_z;
  logic          dist_valid, dist_last;
  logic [AW-1:0] dist_pos;
  logic [DW-1:0] dsq;
  logic [SUM_W-1:0] sum;
  logic [DW-1:0] dist_sat;
  logic          lt_loop;

  assign n = ({{(32-COUNT_W){1'b0}}, cfg_count} < 32'(MAX_WAYPOINTS))
             ? CNT_W'(cfg_count) : CNT_W'(MAX_WAYPOINTS);

  always_comb begin
    case (cmd.addr_sel)
      ADDR_SCAN: lpos = scan_p;
      ADDR_NEXT: lpos = next_pos;
      ADDR_ZERO: lpos = '0;
      ADDR_TP:   lpos = tp;
      default:   lpos = '0;
    endcase
  end

  // reversed order maps logical p to n-1-p
  assign rpos    = n - CNT_W'(1) - CNT_W'(lpos);
  assign raddr   = reversed ? rpos[AW-1:0] : lpos;
  assign slot_ok = {{(32-SLOT_W){1'b0}}, slot_r} < 32'(MAX_WAYPOINTS);

  wfn_ram #(
    .WIDTH (WP_W),
    .DEPTH (MAX_WAYPOINTS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.ram_we && slot_ok),
    .waddr (AW'(slot_r)),
    .wdata ({pz, py, px}),
    .re    (cmd.rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= kind;
      px     <= pos_x;
      py     <= pos_y;
      pz     <= pos_z;
      slot_r <= slot;
    end
  end

  // distance pipe: abs diff, squares, saturating sum
  assign sum = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);

  if (SUM_W > SAT_W) begin : g_sat
    assign dist_sat = (|sum[SUM_W-1:SAT_W]) ? '1 : sum[DW-1:0];
  end else begin : g_nosat
    assign dist_sat = sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t0_valid   <= 1'b0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      dist_valid <= 1'b0;
    end else begin
      t0_valid   <= cmd.tag;
      s1_valid   <= t0_valid;
      s2_valid   <= s1_valid;
      dist_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    t0_last   <= cmd.tag_last;
    t0_pos    <= lpos;
    s1_last   <= t0_last;
    s1_pos    <= t0_pos;
    m_x       <= abs_diff(px, rdata[CB-1:0]);
    m_y       <= abs_diff(py, rdata[2*CB-1:CB]);
    m_z       <= abs_diff(pz, rdata[3*CB-1:2*CB]);
    s2_last   <= s1_last;
    s2_pos    <= s1_pos;
    sq_x      <= {{CB{1'b0}}, m_x} * {{CB{1'b0}}, m_x};
    sq_y      <= {{CB{1'b0}}, m_y} * {{CB{1'b0}}, m_y};
    sq_z      <= {{CB{1'b0}}, m_z} * {{CB{1'b0}}, m_z};
    dist_last <= s2_last;
    dist_pos  <= s2_pos;
    dsq       <= dist_sat;
  end

  // first strictly smaller distance wins
  always_ff @(posedge clk) begin
    if (cmd.scan_acc && dist_valid && ((dist_pos == '0) || (dsq < best_d))) begin
      best_d <= dsq;
      best_p <= dist_pos;
    end
  end

  assign lt_loop = CMP_W'(dsq) < CMP_W'(cfg_loop);

  always_ff @(posedge clk) begin
    if (rst) begin
      next_pos   <= '0;
      next_known <= 1'b0;
      reversed   <= 1'b0;
      scan_p     <= '0;
    end else begin
      if (cmd.scan_clr) begin
        scan_p <= '0;
      end else if (cmd.tag && (cmd.addr_sel == ADDR_SCAN)) begin
        scan_p <= scan_p + AW'(1);
      end
      if (cmd.clr_known) begin
        next_known <= 1'b0;
      end
      if (cmd.best_take && (kind_r == KIND_FOLLOW)) begin
        next_pos   <= best_p;
        next_known <= 1'b1;
      end
      if (cmd.adv) begin
        next_pos <= next_pos + AW'(1);
      end
      if (cmd.loop_apply) begin
        next_pos <= '0;
        reversed <= reversed ^ !lt_loop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.best_take) begin
      tp <= best_p;
    end else if (cmd.adv) begin
      tp <= next_pos + AW'(1);
    end else if (cmd.keep) begin
      tp <= next_pos;
    end else if (cmd.loop_apply) begin
      tp <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      has_target   <= cmd.out_hit;
      target_x     <= cmd.out_hit ? rdata[CB-1:0] : '0;
      target_y     <= cmd.out_hit ? rdata[2*CB-1:CB] : '0;
      target_z     <= cmd.out_hit ? rdata[3*CB-1:2*CB] : '0;
      target_pos   <= cmd.out_hit ? POS_W'(tp) : '0;
      walking_back <= reversed;
    end
  end

  assign sts.kind       = kind_r;
  assign sts.empty      = (n == '0);
  assign sts.target_ok  = next_known && (CNT_W'(next_pos) < n);
  assign sts.scan_last  = (CNT_W'(scan_p) == (n - CNT_W'(1)));
  assign sts.dist_valid = dist_valid;
  assign sts.dist_last  = dist_last;
  assign sts.lt_arrive  = CMP_W'(dsq) < CMP_W'(cfg_arrive);
  assign sts.wrap       = (CNT_W'(next_pos) + CNT_W'(1)) >= n;
  assign sts.out_free   = !out_valid || !out_stall;

endmodule

FILE: rtl/wfn_checker.sv
// Port-level checker for the waypoint follower, bound to the top level.
// Depends on waypoint_follower_nearest_top_assert.svh for the macros.
`include "waypoint_follower_nearest_top_assert.svh"

module wfn_checker #(
  parameter int COORD_BITS = 24
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         has_target,
  input logic signed [COORD_BITS-1:0] target_x,
  input logic signed [COORD_BITS-1:0] target_y,
  input logic signed [COORD_BITS-1:0] target_z,
  input logic [5:0]                   target_pos,
  input logic                         walking_back
);

  // an item without a target carries zero coordinates and position
  `WFN_ASSERT_NOW(a_no_target_zero, out_valid && !has_target, target_x == '0 && target_y == '0 && target_z == '0 && target_pos == '0, "result without target has non-zero fields")

  // a stalled result holds
  `WFN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(has_target) && $stable(target_x) && $stable(target_y) && $stable(target_z) && $stable(target_pos) && $stable(walking_back), "stalled result changed")

  // one item at a time: busy right after acceptance
  `WFN_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken again straight after an item")

  // a new result is only loaded while an item is in progress
  `WFN_ASSERT_NOW(a_result_from_item, $rose(out_valid), $past(in_stall), "result appeared with no item in progress")

endmodule

bind waypoint_follower_nearest_top wfn_checker #(
  .COORD_BITS (COORD_BITS)
) u_wfn_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .has_target   (has_target),
  .target_x     (target_x),
  .target_y     (target_y),
  .target_z     (target_z),
  .target_pos   (target_pos),
  .walking_back (walking_back)
);
